/* rtl/mtrd_pkg.sv */
// Shared types, constants and functions for the MT19937 range draw block.
// Used by mtrd_ctrl, mtrd_dp and the top level; depends on nothing.

package mtrd_pkg;

   // Generator geometry
   localparam int STATE_WORDS  = 624;
   localparam int SHIFT_OFFSET = 397;
   localparam int IDX_W        = $clog2(STATE_WORDS + 2);
   localparam int WORD_W       = 32;
   localparam int SPAN_W       = WORD_W + 1;

   localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(STATE_WORDS - 1);
   localparam logic [IDX_W-1:0] IDX_REGEN  = IDX_W'(STATE_WORDS);
   localparam logic [IDX_W-1:0] IDX_UNSEED = IDX_W'(STATE_WORDS + 1);
   localparam logic [IDX_W-1:0] IDX_FAR    = IDX_W'(SHIFT_OFFSET);
   localparam logic [IDX_W-1:0] IDX_WRAP   = IDX_W'(STATE_WORDS - SHIFT_OFFSET);

   // Algorithm constants
   localparam logic [WORD_W-1:0] TW_MATRIX   = 32'h9908_b0df;
   localparam logic [WORD_W-1:0] TW_UPPER    = 32'h8000_0000;
   localparam logic [WORD_W-1:0] TW_LOWER    = 32'h7fff_ffff;
   localparam logic [WORD_W-1:0] TW_INIT_MUL = 32'd1812433253;
   localparam logic [WORD_W-1:0] TW_TEMPER_B = 32'h9d2c_5680;
   localparam logic [WORD_W-1:0] TW_TEMPER_C = 32'hefc6_0000;
   localparam logic [WORD_W-1:0] TW_RESET_SEED = 32'd5489;

   // Per-cycle command from the controller to the datapath
   typedef enum logic [2:0] {
      OP_NONE,
      OP_ACCEPT,   // capture bounds of the incoming transaction
      OP_FILL,     // write one seeded word (index 0 takes the seed)
      OP_PRIME,    // read word 0 ahead of the twist pass
      OP_TWIST,    // read next/far words; write the twisted word in the next cycle
      OP_DRAW,     // read the word to temper
      OP_OUT       // load the result register
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [IDX_W-1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic out_free;   // result register empty or being taken this cycle
   } status_type;

   // Output tempering
   function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
      logic [WORD_W-1:0] y;
      y = w;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & TW_TEMPER_B);
      y = y ^ ((y << 15) & TW_TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

   // One step of the twist recurrence
   function automatic logic [WORD_W-1:0] twist(input logic [WORD_W-1:0] a,
                                               input logic [WORD_W-1:0] b,
                                               input logic [WORD_W-1:0] far);
      logic [WORD_W-1:0] y;
      logic [WORD_W-1:0] r;
      y = (a & TW_UPPER) | (b & TW_LOWER);
      r = far ^ (y >> 1);
      if (y[0]) begin
         r = r ^ TW_MATRIX;
      end
      return r;
   endfunction

endpackage

/* rtl/mtrd_ram.sv */
// Generic single-write, dual-read RAM with registered read data.
// Holds the twister state words; no dependencies.

module mtrd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 624
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

/* rtl/mtrd_ctrl.sv */
// Sequencer for the range draw: seeding, twist pass and draw steps.
// Depends on mtrd_pkg; drives the datapath through cmd_type commands.

module mtrd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 csr_wr_en,
   input  mtrd_pkg::status_type status,
   output mtrd_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_PRIME,
      ST_TWIST,
      ST_DRAW,
      ST_CALC,
      ST_OUT
   } state_type;

   state_type                  state_ff, state_in;
   logic [mtrd_pkg::IDX_W-1:0] cnt_ff, cnt_in;
   logic [mtrd_pkg::IDX_W-1:0] word_index_ff, word_index_in;

   assign req_tready = (state_ff == ST_IDLE);

   // Next state, counters and per-cycle command
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      word_index_in = word_index_ff;
      cmd.op        = mtrd_pkg::OP_NONE;
      cmd.idx       = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (csr_wr_en) begin
               word_index_in = mtrd_pkg::IDX_UNSEED;
            end
            if (req_tvalid) begin
               cmd.op = mtrd_pkg::OP_ACCEPT;
               cnt_in = '0;
               // a seed written at the accepting edge applies to this draw
               if (csr_wr_en || (word_index_ff == mtrd_pkg::IDX_UNSEED)) begin
                  state_in = ST_FILL;
               end else if (word_index_ff >= mtrd_pkg::IDX_REGEN) begin
                  state_in = ST_PRIME;
               end else begin
                  state_in = ST_DRAW;
               end
            end
         end
         ST_FILL: begin
            cmd.op = mtrd_pkg::OP_FILL;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == mtrd_pkg::IDX_LAST) begin
               state_in = ST_PRIME;
            end
         end
         ST_PRIME: begin
            cmd.op   = mtrd_pkg::OP_PRIME;
            cmd.idx  = '0;
            cnt_in   = '0;
            state_in = ST_TWIST;
         end
         ST_TWIST: begin
            cmd.op = mtrd_pkg::OP_TWIST;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == mtrd_pkg::IDX_LAST) begin
               word_index_in = '0;
               state_in      = ST_DRAW;
            end
         end
         ST_DRAW: begin
            cmd.op        = mtrd_pkg::OP_DRAW;
            cmd.idx       = word_index_ff;
            word_index_in = word_index_ff + 1'b1;
            state_in      = ST_CALC;
         end
         ST_CALC: begin
            // datapath tempers and multiplies the word read last cycle
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.op   = mtrd_pkg::OP_OUT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         word_index_ff <= mtrd_pkg::IDX_UNSEED;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         word_index_ff <= word_index_in;
      end
   end

endmodule

/* rtl/mtrd_dp.sv */
// Datapath for the range draw: state RAM, seed register, seeding multiplier,
// twist and temper logic, range multiply and result register. Uses mtrd_pkg, mtrd_ram.

module mtrd_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  mtrd_pkg::cmd_type    cmd,
   output mtrd_pkg::status_type status,
   input  logic [63:0]          req_tdata,
   input  logic                 csr_wr_en,
   input  logic [31:0]          csr_wr_data,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata
);

   localparam int W  = mtrd_pkg::WORD_W;
   localparam int AW = $clog2(mtrd_pkg::STATE_WORDS);

   logic [W-1:0]                 seed_ff;
   logic [W-1:0]                 lo_ff;
   logic [mtrd_pkg::SPAN_W-1:0]  span_ff;
   mtrd_pkg::op_type             op_q_ff;
   logic [mtrd_pkg::IDX_W-1:0]   idx_q_ff;
   logic [W-1:0]                 cur_ff;
   logic [W-1:0]                 fill_prev_ff;
   logic [W-1:0]                 word_ff;
   logic [W-1:0]                 prod_hi_ff;
   logic                         rsp_valid_ff;
   logic [W-1:0]                 rsp_data_ff;

   logic [W-1:0]               in_a, in_b, bnd_lo, bnd_hi;
   logic [mtrd_pkg::IDX_W-1:0] nxt_idx, far_idx, far_sum;
   logic [mtrd_pkg::IDX_W-1:0] rd_idx_a, wr_idx;
   logic [W-1:0]               fill_mix, fill_word, wr_word;
   logic                       wr_en;
   logic [W-1:0]               rd_a, rd_b;
   logic [W-1:0]               tempered;
   logic [2*W-1:0]             product;
   logic [W-1:0]               offset;

   // Bounds in order
   assign in_a   = req_tdata[W-1:0];
   assign in_b   = req_tdata[2*W-1:W];
   assign bnd_lo = (in_a < in_b) ? in_a : in_b;
   assign bnd_hi = (in_a < in_b) ? in_b : in_a;

   // Neighbor indexes for the twist, mod STATE_WORDS by compare and subtract
   assign nxt_idx = (cmd.idx == mtrd_pkg::IDX_LAST) ? '0 : cmd.idx + 1'b1;
   assign far_sum = cmd.idx + mtrd_pkg::IDX_FAR;
   assign far_idx = (cmd.idx >= mtrd_pkg::IDX_WRAP) ? cmd.idx - mtrd_pkg::IDX_WRAP : far_sum;
   assign rd_idx_a = (cmd.op == mtrd_pkg::OP_TWIST) ? nxt_idx : cmd.idx;

   // Seeding recurrence: word i = MUL * (p ^ (p >> 30)) + i
   assign fill_mix  = fill_prev_ff ^ (fill_prev_ff >> 30);
   assign fill_word = (cmd.idx == '0) ? seed_ff
                    : (mtrd_pkg::TW_INIT_MUL * fill_mix) + W'(cmd.idx);

   // Single write port: seeding now, or the twist result in the cycle after its read
   assign wr_en   = (cmd.op == mtrd_pkg::OP_FILL) || (op_q_ff == mtrd_pkg::OP_TWIST);
   assign wr_idx  = (cmd.op == mtrd_pkg::OP_FILL) ? cmd.idx : idx_q_ff;
   assign wr_word = (cmd.op == mtrd_pkg::OP_FILL) ? fill_word
                  : mtrd_pkg::twist(cur_ff, rd_a, rd_b);

   mtrd_ram #(
      .WIDTH (W),
      .DEPTH (mtrd_pkg::STATE_WORDS)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_idx[AW-1:0]),
      .wr_data   (wr_word),
      .rd_addr_a (rd_idx_a[AW-1:0]),
      .rd_data_a (rd_a),
      .rd_addr_b (far_idx[AW-1:0]),
      .rd_data_b (rd_b)
   );

   // Temper and range multiply on the drawn word
   assign tempered = mtrd_pkg::temper(rd_a);
   assign product  = tempered * span_ff[W-1:0];
   // a span of 2^32 passes the word straight through
   assign offset   = span_ff[W] ? word_ff : prod_hi_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= mtrd_pkg::TW_RESET_SEED;
         op_q_ff      <= mtrd_pkg::OP_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            seed_ff <= csr_wr_data;
         end
         op_q_ff <= cmd.op;
         if (cmd.op == mtrd_pkg::OP_OUT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_q_ff <= cmd.idx;
      if (cmd.op == mtrd_pkg::OP_ACCEPT) begin
         lo_ff   <= bnd_lo;
         span_ff <= {1'b0, bnd_hi - bnd_lo} + 1'b1;
      end
      if (cmd.op == mtrd_pkg::OP_FILL) begin
         fill_prev_ff <= fill_word;
      end
      if ((op_q_ff == mtrd_pkg::OP_PRIME) || (op_q_ff == mtrd_pkg::OP_TWIST)) begin
         cur_ff <= rd_a;
      end
      if (op_q_ff == mtrd_pkg::OP_DRAW) begin
         word_ff    <= tempered;
         prod_hi_ff <= product[2*W-1:W];
      end
      if (cmd.op == mtrd_pkg::OP_OUT) begin
         rsp_data_ff <= lo_ff + offset;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;

endmodule

/* rtl/mersenne_twister_range_draw.sv */
// Top level of the MT19937 range draw block.
// Joins mtrd_ctrl and mtrd_dp; types from mtrd_pkg.
//
// Usage:
//  - req channel: one transaction carries two inclusive bounds in any order.
//  - rsp channel: one transaction per request, a tempered MT19937 word mapped
//    into [low, high] as low + ((word * span) >> 32), span = high - low + 1.
//  - csr port: csr_wr_en writes the seed; the state is rebuilt from it before
//    the next draw. Write only while no request is in flight.
// Sequence:
//  - a draw runs from accept through the draw, calc and out steps to the next
//    accept; the out step loads the result for rsp_tvalid. The steps are set by
//    the registered state RAM read, the temper/multiply stage and the add.
//  - every 624th draw adds a twist pass, a prime step and then one word per
//    cycle (two RAM read ports and one write port).
//  - the first draw after reset or after a seed write adds a pass that seeds
//    the 624 state words, one seeding multiply per cycle.
// Reset: seed returns to 5489 and the state is marked unseeded; RAM contents
// are not cleared. If the receiver stalls, the result is held in the output
// register and the next request is still taken; its result waits until the
// held one is taken.

module mersenne_twister_range_draw (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] range_low, [63:32] range_high
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] value
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data  // seed
);

   mtrd_pkg::cmd_type    cmd;
   mtrd_pkg::status_type status;

   mtrd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .csr_wr_en  (csr_wr_en),
      .status     (status),
      .cmd        (cmd)
   );

   mtrd_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_tdata   (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

/* rtl/mtrd_checker.sv */
// Port-level checks for the MT19937 range draw block, bound to the top level.
// Depends only on the ports of mersenne_twister_range_draw.

module mtrd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [63:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   logic [31:0] lo_ff, hi_ff;
   logic        hold_ff;
   logic        fresh;

   // Bounds of the latest accepted transaction, in order
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         lo_ff <= (req_tdata[31:0] < req_tdata[63:32]) ? req_tdata[31:0] : req_tdata[63:32];
         hi_ff <= (req_tdata[31:0] < req_tdata[63:32]) ? req_tdata[63:32] : req_tdata[31:0];
      end
   end

   // Result shown last cycle and not taken
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= 1'b0;
      end else begin
         hold_ff <= rsp_tvalid && !rsp_tready;
      end
   end

   // A result presented for the first time
   assign fresh = rsp_tvalid && !hold_ff;

   // Stalled result holds its value
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp changed while stalled");

   // Nothing to deliver right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   // One draw at a time: busy after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while a draw is in flight");

   // A new result lies within the bounds of the request that caused it
   a_in_range: assert property (@(posedge clock) disable iff (reset)
      fresh |-> (rsp_tdata >= lo_ff) && (rsp_tdata <= hi_ff))
      else $error("result outside requested bounds");

endmodule

bind mersenne_twister_range_draw mtrd_checker u_mtrd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* verif/testbench.sv */
// Self-checking testbench for mersenne_twister_range_draw (MT19937 range draw).
// Holds its own MT19937 predictor in a scoreboard class; needs only the RTL under rtl/.
`timescale 1ns / 1ps

module testbench;

   // Receiver stall patterns
   typedef enum int {RX_OPEN, RX_COIN, RX_CHOKED, RX_CADENCE} stall_mode_type;

   // Directed bounds, packed {range_high, range_low}
   localparam bit [63:0] EDGE_BOUNDS [16] = '{
      {32'h0000_0000, 32'h0000_0000},   // both at zero
      {32'hffff_ffff, 32'hffff_ffff},   // both at top
      {32'hffff_ffff, 32'h0000_0000},   // full range
      {32'h0000_0000, 32'hffff_ffff},   // full range, reversed
      {32'd3,         32'd5},           // reversed
      {32'd200,       32'd100},
      {32'd1,         32'd0},
      {32'd0,         32'd1},           // reversed, span of two
      {32'hffff_ffff, 32'hffff_fffe},
      {32'h8000_0000, 32'h7fff_ffff},
      {32'h7fff_ffff, 32'h8000_0000},   // reversed across the sign bit
      {32'h7fff_ffff, 32'h0000_0000},
      {32'hffff_ffff, 32'h8000_0000},
      {32'h5555_aaaa, 32'haaaa_5555},   // reversed, alternating bits
      {32'd123,       32'd123},
      {32'hffff_ffff, 32'h0000_0001}
   };

   // Predicts the drawn values and holds the ones not yet seen on rsp
   class range_draw_board_type;
      localparam int          MT_N          = 624;
      localparam int          MT_M          = 397;
      localparam int          POS_REGEN     = MT_N;
      localparam int          POS_UNSEEDED  = MT_N + 1;
      localparam bit [31:0]   MT_MATRIX     = 32'h9908_b0df;
      localparam bit [31:0]   MT_UPPER      = 32'h8000_0000;
      localparam bit [31:0]   MT_LOWER      = 32'h7fff_ffff;
      localparam bit [31:0]   MT_SEED_MUL   = 32'd1812433253;
      localparam bit [31:0]   MT_TEMPER_B   = 32'h9d2c_5680;
      localparam bit [31:0]   MT_TEMPER_C   = 32'hefc6_0000;
      localparam bit [31:0]   MT_POWERUP    = 32'd5489;

      bit [31:0] twister[MT_N];
      int        draw_pos;
      bit [31:0] seed_val;
      bit [31:0] expected_values[$];
      int        errors;

      function new();
         seed_val = MT_POWERUP;
         draw_pos = POS_UNSEEDED;
         errors   = 0;
      endfunction

      // Seed write: state is rebuilt before the next draw
      function void load_seed(bit [31:0] s);
         seed_val = s;
         draw_pos = POS_UNSEEDED;
      endfunction

      function int pending();
         return expected_values.size();
      endfunction

      // Accepted req transaction: draw one word and map it into the bounds
      function void note_bounds(bit [31:0] a, bit [31:0] b);
         bit [31:0] lo;
         bit [31:0] hi;
         bit [32:0] span;
         bit [31:0] y;
         bit [31:0] p;
         bit [64:0] product;
         int        nxt;
         int        far;
         lo = (a < b) ? a : b;
         hi = (a < b) ? b : a;
         span = {1'b0, hi - lo} + 33'd1;
         if (draw_pos >= POS_REGEN) begin
            if (draw_pos == POS_UNSEEDED) begin
               twister[0] = seed_val;
               for (int i = 1; i < MT_N; i++) begin
                  p = twister[i-1];
                  twister[i] = MT_SEED_MUL * (p ^ (p >> 30)) + 32'(i);
               end
            end
            // twist pass, in place
            for (int k = 0; k < MT_N; k++) begin
               nxt = (k + 1) % MT_N;
               far = (k + MT_M) % MT_N;
               y = (twister[k] & MT_UPPER) | (twister[nxt] & MT_LOWER);
               p = twister[far] ^ (y >> 1);
               if (y[0]) begin
                  p = p ^ MT_MATRIX;
               end
               twister[k] = p;
            end
            draw_pos = 0;
         end
         y = twister[draw_pos];
         draw_pos++;
         // tempering
         y = y ^ (y >> 11);
         y = y ^ ((y << 7) & MT_TEMPER_B);
         y = y ^ ((y << 15) & MT_TEMPER_C);
         y = y ^ (y >> 18);
         product = {33'd0, y} * {32'd0, span};
         expected_values.push_back(lo + product[63:32]);
      endfunction

      // Accepted rsp transaction against the oldest prediction
      function void check_value(logic [31:0] actual);
         bit [31:0] want;
         if (expected_values.size() == 0) begin
            $error("value: no transaction expected, actual %h", actual);
            errors++;
         end else begin
            want = expected_values.pop_front();
            if (actual !== want) begin
               $error("value: expected %h, actual %h", want, actual);
               errors++;
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata   = '0;   // [31:0] range_low, [63:32] range_high
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [31:0] rsp_tdata;          // [31:0] value
   logic        csr_wr_en   = 1'b0;
   logic [31:0] csr_wr_data = '0;   // seed

   range_draw_board_type board;
   stall_mode_type       rx_mode  = RX_OPEN;
   int                   rx_cycle = 0;

   mersenne_twister_range_draw i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Receiver: stall pattern redrawn at random from the four modes as the run goes on
   always @(posedge clock) begin
      if (rx_cycle % 97 == 0) begin
         rx_mode = stall_mode_type'($urandom_range(0, 3));
      end
      rx_cycle++;
      case (rx_mode)
         RX_OPEN:    rsp_tready <= 1'b1;
         RX_COIN:    rsp_tready <= 1'($urandom_range(0, 1));
         RX_CHOKED:  rsp_tready <= ($urandom_range(0, 7) == 0);
         default:    rsp_tready <= (rx_cycle % 5) < 2;
      endcase
   end

   // Both channels sampled at the same edge; predictions go in first
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            board.note_bounds(req_tdata[31:0], req_tdata[63:32]);
         end
         if (rsp_tvalid && rsp_tready) begin
            board.check_value(rsp_tdata);
         end
      end
   end

   // Present one pair of bounds and hold it until the handshake
   task automatic send_bounds(input bit [31:0] lo, input bit [31:0] hi);
      req_tvalid <= 1'b1;
      req_tdata  <= {hi, lo};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic pause_requests(input int cycles);
      if (cycles > 0) begin
         req_tvalid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Idle means every predicted value has come back; the first edge lets the
   // monitor note the last accepted transaction
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_seed(input bit [31:0] s);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= s;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      board.load_seed(s);
   endtask

   // Random bounds in bursts with random gaps
   task automatic run_random(input int count);
      int        burst_left;
      int        gap;
      bit [31:0] a;
      bit [31:0] b;
      burst_left = 0;
      repeat (count) begin
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 60) : $urandom_range(0, 4);
            pause_requests(gap);
            burst_left = $urandom_range(1, 40);
         end
         burst_left--;
         a = $urandom;
         b = $urandom;
         case ($urandom_range(0, 7))
            0: b = a + $urandom_range(0, 15);            // narrow span, may wrap
            1: begin a = 32'h0; b = 32'hffff_ffff; end   // full range
            2: begin a = 32'hffff_ffff; b = 32'h0; end   // full range, reversed
            3: b = a;                                    // single value
            4: begin a = $urandom_range(0, 255); b = $urandom_range(0, 255); end
            5: begin a = ~32'($urandom_range(0, 255)); b = ~32'($urandom_range(0, 255)); end
            default: ;
         endcase
         send_bounds(a, b);
      end
   endtask

   initial begin
      board = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // power-up seed: edge bounds, then enough draws to pass a twist pass
      foreach (EDGE_BOUNDS[i]) begin
         send_bounds(EDGE_BOUNDS[i][31:0], EDGE_BOUNDS[i][63:32]);
      end
      run_random(640);

      // reseed mid-block with the extremes, a random seed and the default
      wait_idle();
      write_seed(32'h0000_0000);
      run_random(15);
      wait_idle();
      write_seed(32'hffff_ffff);
      run_random(15);
      wait_idle();
      write_seed($urandom);
      run_random(15);
      wait_idle();
      write_seed(32'd5489);
      run_random(15);

      wait_idle();
      repeat (20) @(posedge clock);
      if (board.errors == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

   // Run limit: a run still going at this delay fails
   initial begin
      #8_000_000;
      $display("testbench: FAIL");
      $finish;
   end

endmodule
